// ===== hw/rtl/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsb_pkg
// Types and fixed constants of the transport-stream stream-id blocker.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam int         ERROR_BIT     = 7;
  localparam logic [7:0] PID_HIGH_MASK = 8'h1F;
  localparam logic [7:0] PAT_PID_BYTE  = 8'h00;
  localparam int         HEADER_BYTES  = 10;
  localparam int         HDR_IW        = $clog2(HEADER_BYTES);
  localparam logic [HDR_IW-1:0] HDR_LAST = HDR_IW'(HEADER_BYTES - 1);

  typedef enum logic {
    OP_STREAM      = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_STOP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_STOP,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/tsb_in_if.sv =====
// ----------------------------------------------------------------------------
// tsb_in_if
// Input channel: stream bytes and block list writes, valid/ready transfer.
// ----------------------------------------------------------------------------
interface tsb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  data_byte;
  logic [6:0]  entry_index;
  logic [15:0] entry_value;

  modport source (
    output valid, operation, data_byte, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, operation, data_byte, entry_index, entry_value,
    output ready
  );
endinterface

// ===== hw/rtl/tsb_out_if.sv =====
// ----------------------------------------------------------------------------
// tsb_out_if
// Result channel: forwarded bytes and stop events, valid/ready transfer.
// ----------------------------------------------------------------------------
interface tsb_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        end_of_packet;
  logic        last_of_run;
  logic [15:0] stream_id;

  modport source (
    output valid, kind, out_byte, end_of_packet, last_of_run, stream_id,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, end_of_packet, last_of_run, stream_id,
    output ready
  );
endinterface

// ===== hw/rtl/ts_packet_stream_id_blocker.sv =====
// Input: one transfer per cycle while idle and the output register is free; a
// forwarded byte is valid at the output in the next cycle and held for a stalled sink.
// Byte 9 of a passing packet stalls the input while the held header is released;
// for PID 0 with a non-empty list a walk of up to min(entry_count, TABLE_DEPTH)
// entries, one entry per cycle, comes first.
// Reset: synchronous, active low; clears control state, list is undefined.
// ----------------------------------------------------------------------------
// ts_packet_stream_id_blocker
// Transport-stream packet filter with a loadable list of blocked stream ids.
// ----------------------------------------------------------------------------
module ts_packet_stream_id_blocker #(
  parameter int TABLE_DEPTH  = 128,
  parameter int PACKET_BYTES = 188
) (
  input  logic       clk,
  input  logic       rst_n,
  tsb_in_if.sink     in_if,
  tsb_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > 8) ? CW : 8;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // block list memory
  logic [15:0] mem [TABLE_DEPTH];
  logic [15:0] mem_rd_r;

  tsb_pkg::state_t state_r, state_nxt;

  logic [7:0]  entry_count_r;
  logic        in_packet_r, in_packet_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        drop_r, drop_nxt;
  logic        halted_r, halted_nxt;
  logic        pid_zero_r, pid_zero_nxt;
  logic [7:0]  sid_hi_r, sid_hi_nxt;
  logic [15:0] sid_r, sid_nxt;
  logic        emit_last_r, emit_last_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [tsb_pkg::HDR_IW-1:0] emit_idx_r, emit_idx_nxt;
  logic [7:0]  hdr_r [tsb_pkg::HEADER_BYTES];

  logic        out_valid_r, out_valid_nxt;
  tsb_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        eop_r, eop_nxt;
  logic        olast_r, olast_nxt;
  logic [15:0] osid_r, osid_nxt;

  logic          slot_free, in_ready, in_fire, byte_acc, tbl_we;
  logic          lk_hit, lk_issue, lk_done, emit_go, stop_go;
  logic          start_lookup, start_emit, byte_out, hdr_we, last_byte, drop_eff;
  logic [NW-1:0] ec_w, n_w;
  logic [AW-1:0] wr_addr, rd_addr;

  assign slot_free = !out_valid_r || out_if.ready;
  assign in_fire   = in_if.valid && in_ready;
  assign byte_acc  = in_fire && (in_if.operation == tsb_pkg::OP_STREAM) && !halted_r;
  assign tbl_we    = in_fire && (in_if.operation == tsb_pkg::OP_TABLE_WRITE) &&
                     (32'(in_if.entry_index) < TABLE_DEPTH);
  assign wr_addr   = AW'(in_if.entry_index);
  assign rd_addr   = idx_r[AW-1:0];
  assign ec_w      = NW'(entry_count_r);
  assign n_w       = (ec_w > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : ec_w;
  assign last_byte = (9'(pos_r) + 9'd1) >= 9'(PACKET_BYTES);
  assign drop_eff  = (pos_r == 8'd1) ? in_if.data_byte[tsb_pkg::ERROR_BIT] : drop_r;

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = kind_r;
  assign out_if.out_byte      = obyte_r;
  assign out_if.end_of_packet = eop_r;
  assign out_if.last_of_run   = olast_r;
  assign out_if.stream_id     = osid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsb_pkg::ST_IDLE: begin
        if (start_lookup) begin
          state_nxt = tsb_pkg::ST_LOOKUP;
        end else if (start_emit) begin
          state_nxt = tsb_pkg::ST_EMIT;
        end
      end
      tsb_pkg::ST_LOOKUP: begin
        if (lk_hit) begin
          state_nxt = tsb_pkg::ST_STOP;
        end else if (lk_done) begin
          state_nxt = tsb_pkg::ST_EMIT;
        end
      end
      tsb_pkg::ST_STOP: begin
        if (slot_free) begin
          state_nxt = tsb_pkg::ST_IDLE;
        end
      end
      tsb_pkg::ST_EMIT: begin
        if (slot_free && emit_idx_r == tsb_pkg::HDR_LAST) begin
          state_nxt = tsb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsb_pkg::ST_IDLE;
    endcase
  end

  // state outputs; list memory is not read while input transfers are taken
  always_comb begin
    in_ready = 1'b0;
    lk_hit   = 1'b0;
    lk_issue = 1'b0;
    lk_done  = 1'b0;
    emit_go  = 1'b0;
    stop_go  = 1'b0;
    unique case (state_r)
      tsb_pkg::ST_IDLE: in_ready = slot_free;
      tsb_pkg::ST_LOOKUP: begin
        lk_hit   = rd_pend_r && (mem_rd_r == sid_r);
        lk_issue = !lk_hit && (idx_r < n_w);
        lk_done  = !lk_hit && (idx_r >= n_w);
      end
      tsb_pkg::ST_STOP: stop_go = slot_free;
      tsb_pkg::ST_EMIT: emit_go = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  // stream datapath
  always_comb begin
    in_packet_nxt = in_packet_r;
    pos_nxt       = pos_r;
    drop_nxt      = drop_r;
    halted_nxt    = halted_r;
    pid_zero_nxt  = pid_zero_r;
    sid_hi_nxt    = sid_hi_r;
    sid_nxt       = sid_r;
    emit_last_nxt = emit_last_r;
    start_lookup  = 1'b0;
    start_emit    = 1'b0;
    byte_out      = 1'b0;
    hdr_we        = 1'b0;

    if (byte_acc) begin
      if (!in_packet_r) begin
        if (in_if.data_byte == tsb_pkg::SYNC_BYTE) begin
          in_packet_nxt = 1'b1;
          pos_nxt       = 8'd1;
          drop_nxt      = 1'b0;
          hdr_we        = 1'b1;
        end
      end else begin
        drop_nxt = drop_eff;
        hdr_we   = pos_r < 8'(tsb_pkg::HEADER_BYTES);
        if (pos_r == 8'd1) begin
          pid_zero_nxt = (in_if.data_byte & tsb_pkg::PID_HIGH_MASK) == tsb_pkg::PAT_PID_BYTE;
        end
        if (pos_r == 8'd2) begin
          pid_zero_nxt = pid_zero_r && (in_if.data_byte == tsb_pkg::PAT_PID_BYTE);
        end
        if (pos_r == 8'd8) begin
          sid_hi_nxt = in_if.data_byte;
        end
        if (pos_r == 8'(tsb_pkg::HEADER_BYTES - 1)) begin
          sid_nxt       = {sid_hi_r, in_if.data_byte};
          emit_last_nxt = last_byte;
          if (!drop_eff) begin
            if (pid_zero_r && n_w != '0) begin
              start_lookup = 1'b1;
            end else begin
              start_emit = 1'b1;
            end
          end
        end else if (pos_r >= 8'(tsb_pkg::HEADER_BYTES)) begin
          byte_out = !drop_eff;
        end
        if (last_byte) begin
          in_packet_nxt = 1'b0;
          pos_nxt       = '0;
        end else begin
          pos_nxt = pos_r + 8'd1;
        end
      end
    end

    if (stop_go) begin
      halted_nxt    = 1'b1;
      in_packet_nxt = 1'b0;
      pos_nxt       = '0;
    end
  end

  // lookup and release counters
  always_comb begin
    idx_nxt      = idx_r;
    emit_idx_nxt = emit_idx_r;
    rd_pend_nxt  = lk_issue;
    if (start_lookup) begin
      idx_nxt = '0;
    end else if (lk_issue) begin
      idx_nxt = idx_r + NW'(1);
    end
    if (start_emit || lk_done) begin
      emit_idx_nxt = '0;
    end else if (emit_go) begin
      emit_idx_nxt = emit_idx_r + tsb_pkg::HDR_IW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    obyte_nxt     = obyte_r;
    eop_nxt       = eop_r;
    olast_nxt     = olast_r;
    osid_nxt      = osid_r;
    priority if (byte_out) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = tsb_pkg::KIND_BYTE;
      obyte_nxt     = in_if.data_byte;
      eop_nxt       = last_byte;
      olast_nxt     = 1'b1;
      osid_nxt      = '0;
    end else if (emit_go) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = tsb_pkg::KIND_BYTE;
      obyte_nxt     = hdr_r[emit_idx_r];
      eop_nxt       = (emit_idx_r == tsb_pkg::HDR_LAST) && emit_last_r;
      olast_nxt     = emit_idx_r == tsb_pkg::HDR_LAST;
      osid_nxt      = '0;
    end else if (stop_go) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = tsb_pkg::KIND_STOP;
      obyte_nxt     = '0;
      eop_nxt       = 1'b0;
      olast_nxt     = 1'b1;
      osid_nxt      = sid_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tsb_pkg::ST_IDLE;
      entry_count_r <= '0;
      in_packet_r   <= 1'b0;
      pos_r         <= '0;
      drop_r        <= 1'b0;
      halted_r      <= 1'b0;
      idx_r         <= '0;
      rd_pend_r     <= 1'b0;
      emit_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      in_packet_r <= in_packet_nxt;
      pos_r       <= pos_nxt;
      drop_r      <= drop_nxt;
      halted_r    <= halted_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_zero_r  <= pid_zero_nxt;
    sid_hi_r    <= sid_hi_nxt;
    sid_r       <= sid_nxt;
    emit_last_r <= emit_last_nxt;
    kind_r      <= kind_nxt;
    obyte_r     <= obyte_nxt;
    eop_r       <= eop_nxt;
    olast_r     <= olast_nxt;
    osid_r      <= osid_nxt;
    if (hdr_we) begin
      hdr_r[pos_r[tsb_pkg::HDR_IW-1:0]] <= in_if.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[wr_addr] <= in_if.entry_value;
    end
    if (lk_issue) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == tsb_pkg::KIND_STOP) |-> halted_r)
    else $error("stop event without halt");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt cleared without reset");

  a_lookup_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsb_pkg::ST_LOOKUP) |-> (in_packet_r && !drop_r &&
      pos_r == 8'(tsb_pkg::HEADER_BYTES)))
    else $error("list lookup outside a passing header");

  a_pend_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == tsb_pkg::ST_LOOKUP))
    else $error("list read data outside lookup");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsb_pkg::ST_EMIT) |-> (emit_idx_r <= tsb_pkg::HDR_LAST))
    else $error("header release index out of range");

endmodule

// ===== bench/tsb_blocker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsb_blocker_checker
// Watches both channels and the count register of the stream-id blocker,
// predicts the forwarded bytes and stop events of every input transfer and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tsb_blocker_checker #(
  parameter int TABLE_DEPTH  = 128,
  parameter int PACKET_BYTES = 188
) (
  input  logic       clk,
  input  logic       rst_n,
  tsb_in_if          in_mon,
  tsb_out_if         out_mon,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         errors,
  output int         pending,
  output int         bytes_fwd,
  output int         stops_seen
);

  typedef struct packed {
    tsb_pkg::kind_t kind;
    logic [7:0]     data;
    logic           eop;
    logic           last_run;
    logic [15:0]    sid;
  } tsb_result_t;

  logic [7:0]  list_len;
  logic        in_pkt;
  logic [7:0]  pos;
  logic [7:0]  hdr [0:tsb_pkg::HEADER_BYTES-1];
  logic        drop;
  logic        halted;
  logic [15:0] id_list [0:TABLE_DEPTH-1];

  tsb_result_t due_results [$];

  function automatic bit id_listed(input logic [15:0] sid);
    int lim;
    lim = (int'(list_len) > TABLE_DEPTH) ? TABLE_DEPTH : int'(list_len);
    for (int i = 0; i < lim; i++) begin
      if (id_list[i] == sid) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic string fmt_result(input tsb_result_t r);
    return $sformatf("kind=%0d byte=%02h eop=%0d last=%0d sid=%04h",
                     r.kind, r.data, r.eop, r.last_run, r.sid);
  endfunction

  task automatic filter_input(input tsb_pkg::op_t op, input logic [7:0] b,
                              input logic [6:0] idx, input logic [15:0] val);
    logic        at_end;
    logic [12:0] pid;
    logic [15:0] sid;
    tsb_result_t r;
    if (op == tsb_pkg::OP_TABLE_WRITE) begin
      if (int'(idx) < TABLE_DEPTH) id_list[idx] = val;
    end else if (!halted) begin
      if (!in_pkt) begin
        if (b == tsb_pkg::SYNC_BYTE) begin
          in_pkt = 1'b1;
          pos    = 8'd1;
          hdr[0] = b;
          drop   = 1'b0;
        end
      end else begin
        if (pos == 8'd1) drop = b[tsb_pkg::ERROR_BIT];
        if (int'(pos) < tsb_pkg::HEADER_BYTES) hdr[pos] = b;
        at_end = (int'(pos) + 1 >= PACKET_BYTES);
        if (!drop && int'(pos) == tsb_pkg::HEADER_BYTES - 1) begin
          pid = {hdr[1][4:0] & tsb_pkg::PID_HIGH_MASK[4:0], hdr[2]};
          sid = {hdr[8], hdr[9]};
          if (pid == 13'(tsb_pkg::PAT_PID_BYTE) && id_listed(sid)) begin
            r = '{kind: tsb_pkg::KIND_STOP, data: 8'h00, eop: 1'b0, last_run: 1'b1,
                  sid: sid};
            due_results.push_back(r);
            halted = 1'b1;
            in_pkt = 1'b0;
            pos    = 8'd0;
          end else begin
            for (int k = 0; k < tsb_pkg::HEADER_BYTES; k++) begin
              r = '{kind: tsb_pkg::KIND_BYTE, data: hdr[k],
                    eop: (k == tsb_pkg::HEADER_BYTES - 1) && at_end,
                    last_run: (k == tsb_pkg::HEADER_BYTES - 1), sid: 16'h0000};
              due_results.push_back(r);
            end
          end
        end else if (!drop && int'(pos) >= tsb_pkg::HEADER_BYTES) begin
          r = '{kind: tsb_pkg::KIND_BYTE, data: b, eop: at_end, last_run: 1'b1,
                sid: 16'h0000};
          due_results.push_back(r);
        end
        if (!halted) begin
          if (at_end) begin
            in_pkt = 1'b0;
            pos    = 8'd0;
          end else begin
            pos = pos + 8'd1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    tsb_result_t got;
    tsb_result_t want;
    if (!rst_n) begin
      list_len   = 8'd0;
      in_pkt     = 1'b0;
      pos        = 8'd0;
      drop       = 1'b0;
      halted     = 1'b0;
      errors     = 0;
      bytes_fwd  = 0;
      stops_seen = 0;
      due_results.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{kind: tsb_pkg::kind_t'(out_mon.kind), data: out_mon.out_byte,
                eop: out_mon.end_of_packet, last_run: out_mon.last_of_run,
                sid: out_mon.stream_id};
        if (got.kind == tsb_pkg::KIND_STOP) stops_seen++;
        else bytes_fwd++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: %s", $time, fmt_result(got));
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %s actual %s", $time,
                     fmt_result(want), fmt_result(got));
          end
        end
      end
      if (cfg_we === 1'b1) list_len = cfg_wdata;
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        filter_input(tsb_pkg::op_t'(in_mon.operation), in_mon.data_byte,
                     in_mon.entry_index, in_mon.entry_value);
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== bench/tb_ts_packet_stream_id_blocker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ts_packet_stream_id_blocker
// Drives the stream-id blocker with hunting noise, a passing and an errored
// packet and block list writes under three handshake pressures; ends with a
// blocked PAT packet that halts forwarding. Checking is done by
// tsb_blocker_checker.
// ----------------------------------------------------------------------------
module tb_ts_packet_stream_id_blocker;

  localparam int TABLE_DEPTH  = 128;
  localparam int PACKET_BYTES = 188;
  localparam int PHASE_ITEMS  = 130;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int errors;
  int pending;
  int bytes_fwd;
  int stops_seen;

  int send_idle;
  int recv_idle;
  int n_items;
  int n_packets;
  int n_writes;
  int list_len;

  logic [15:0] list_mirror [0:TABLE_DEPTH-1];

  tsb_in_if  in_if ();
  tsb_out_if out_if ();

  ts_packet_stream_id_blocker #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PACKET_BYTES (PACKET_BYTES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tsb_blocker_checker #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .bytes_fwd  (bytes_fwd),
    .stops_seen (stops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still due", $time, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_idle);
  end

  function automatic int search_len();
    return (list_len > TABLE_DEPTH) ? TABLE_DEPTH : list_len;
  endfunction

  function automatic bit id_listed(input logic [15:0] sid);
    for (int i = 0; i < search_len(); i++) begin
      if (list_mirror[i] == sid) return 1'b1;
    end
    return 1'b0;
  endfunction

  // unlisted id, half of the time taken from a slot past the searched ones
  function automatic logic [15:0] pick_clear_id();
    logic [15:0] sid;
    if (search_len() < TABLE_DEPTH && $urandom_range(1) == 1)
      sid = list_mirror[$urandom_range(TABLE_DEPTH - 1, search_len())];
    else
      sid = 16'($urandom);
    while (id_listed(sid)) sid = 16'($urandom);
    return sid;
  endfunction

  function automatic logic [15:0] pick_listed_id();
    if (search_len() == 0) return 16'($urandom);
    return list_mirror[$urandom_range(search_len() - 1)];
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == tsb_pkg::SYNC_BYTE) b = ~b;
    return b;
  endfunction

  task automatic send_item(input tsb_pkg::op_t op, input logic [7:0] b,
                           input logic [6:0] idx, input logic [15:0] val);
    if (n_items == PHASE_ITEMS) begin
      send_idle = 45;
      recv_idle = 8;
    end else if (n_items == 2 * PHASE_ITEMS) begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.operation   = op;
    in_if.data_byte   = b;
    in_if.entry_index = idx;
    in_if.entry_value = val;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
    n_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(tsb_pkg::OP_STREAM, b, 7'($urandom), 16'($urandom));
  endtask

  task automatic write_entry(input logic [6:0] idx, input logic [15:0] val);
    send_item(tsb_pkg::OP_TABLE_WRITE, 8'($urandom), idx, val);
    list_mirror[idx] = val;
    n_writes++;
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_list_len(input int len);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = 8'(len);
    @(negedge clk);
    cfg_we    = 1'b0;
    list_len  = len;
  endtask

  task automatic send_packet(input bit err, input bit pat, input logic [15:0] sid,
                             input bit mix_writes, input int n_send);
    logic [7:0]  pkt [0:PACKET_BYTES-1];
    logic [15:0] val;
    for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'($urandom);
    pkt[0] = tsb_pkg::SYNC_BYTE;
    pkt[1] = {err, pkt[1][6:5], pat ? 5'd0 : pkt[1][4:0]};
    if (pat) pkt[2] = tsb_pkg::PAT_PID_BYTE;
    else if (pkt[1][4:0] == 5'd0 && pkt[2] == 8'h00) pkt[2] = 8'h01;
    pkt[8] = sid[15:8];
    pkt[9] = sid[7:0];
    for (int i = 0; i < n_send; i++) begin
      if (mix_writes && $urandom_range(99) < 3) begin
        val = 16'($urandom);
        if (val == sid) val = val ^ 16'h0001;
        write_entry(7'($urandom), val);
      end
      send_byte(pkt[i]);
    end
    n_packets++;
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.operation   = tsb_pkg::OP_STREAM;
    in_if.data_byte   = 8'h00;
    in_if.entry_index = 7'd0;
    in_if.entry_value = 16'h0000;
    cfg_we            = 1'b0;
    cfg_wdata         = 8'h00;
    rst_n             = 1'b0;
    send_idle         = 8;
    recv_idle         = 45;
    n_items           = 0;
    n_packets         = 0;
    n_writes          = 0;
    list_len          = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) list_mirror[i] = 16'h0000;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // hunting discards anything but sync
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tsb_pkg::SYNC_BYTE - 8'd1);
    send_byte(tsb_pkg::SYNC_BYTE + 8'd1);
    write_entry(7'd0, 16'h0000);
    write_entry(7'd1, 16'hFFFF);
    write_entry(7'd2, 16'hABCD);
    write_entry(7'd3, 16'h5A5A);
    write_entry(7'd4, 16'($urandom));
    write_entry(7'd5, 16'($urandom));
    write_entry(7'd127, 16'h1234);
    set_list_len(6);

    // PAT packet walks the list without a hit and is forwarded whole
    send_packet(1'b0, 1'b1, pick_clear_id(), 1'b1, PACKET_BYTES);
    // errored PAT packet with a listed id is dropped without lookup
    send_packet(1'b1, 1'b1, pick_listed_id(), 1'b0, PACKET_BYTES);
    repeat (2) send_byte(junk_byte());

    // last searched slot blocks; stream bytes after it are ignored
    set_list_len(3);
    send_packet(1'b0, 1'b1, list_mirror[search_len() - 1], 1'b0,
                tsb_pkg::HEADER_BYTES + 3);
    send_byte(tsb_pkg::SYNC_BYTE);
    repeat (2) send_byte(junk_byte());
    write_entry(7'($urandom), 16'($urandom));

    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d input transfers: %0d packets, %0d list writes, three stall mixes",
             n_items, n_packets, n_writes);
    $display("Checked %0d forwarded bytes and %0d stop events", bytes_fwd, stops_seen);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_in_if.sv
hw/rtl/tsb_out_if.sv
hw/rtl/ts_packet_stream_id_blocker.sv
bench/tsb_blocker_checker.sv
bench/tb_ts_packet_stream_id_blocker.sv
